// ----- rtl/lzf_pkg.sv -----
package lzf_pkg;

  localparam int unsigned WindowBytesDefault = 8192;
  localparam int unsigned LanesDefault       = 8;

  localparam logic [16:0] OutLimitReset = 17'd65536;
  localparam logic [7:0]  LiteralCtrlTop = 8'd32;
  localparam logic [8:0]  ExtendedLen    = 9'd6;
  localparam logic [8:0]  MinMatch       = 9'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_OVERFLOW = 2'd1;
  localparam logic [1:0] ST_DISTANCE = 2'd2;
  localparam logic [1:0] ST_TRUNC    = 2'd3;

  localparam logic [1:0] REG_OUT_LIMIT = 2'd0;

endpackage

// ----- rtl/lzf_byte_decompressor.sv -----
// LZF decompressor, one compressed byte per input transfer.
// Input channel: in_byte, stream_end with in_valid/in_ready. Output channel:
// out_bytes (up to LANES decoded bytes, first byte in lane 0), byte_count,
// total_length, status, block_done, run_last with out_valid/out_ready.
// A control or extension byte gives no output; a literal byte gives one result.
// A back reference of N bytes reads the 8 KiB history RAM one byte at a time
// (registered read, then write back), packing up to LANES bytes into each
// result. A stream_end byte adds a closing result with total_length and status.
// run_last marks the last result of each byte. The history RAM has one write
// port, shared by literal writes and copy write-back. While the output register
// holds an untaken result, the next result waits; a byte that gives no result
// is still taken. Reset clears the parser and out_valid; out_limit returns to
// 65536. History needs no clearing: a copy only reads bytes written earlier in
// the same block. out_limit sits at APB address 0; the user must see that it is
// written only while the block idles, which the block itself does not enforce.
module lzf_byte_decompressor #(
  parameter int unsigned WINDOW_BYTES = lzf_pkg::WindowBytesDefault,
  parameter int unsigned LANES        = lzf_pkg::LanesDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  input  logic        stream_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_bytes,
  output logic [3:0]  byte_count,
  output logic [16:0] total_length,
  output logic [1:0]  status,
  output logic        block_done,
  output logic        run_last
);
  import lzf_pkg::*;

  localparam int unsigned AW = $clog2(WINDOW_BYTES);
  localparam int unsigned WW = 8 * LANES;

  typedef enum logic [2:0] {
    S_IDLE, S_LIT_EMIT, S_COPY_RD, S_COPY_WR, S_COPY_EMIT, S_CLOSE
  } state_t;

  typedef enum logic [1:0] {P_CTRL, P_LIT, P_EXT, P_LOW} phase_t;

  state_t        state;
  phase_t        phase;
  logic [16:0]   out_limit;
  logic [16:0]   out_count;
  logic [5:0]    lit_left;
  logic [8:0]    mlen;
  logic [4:0]    ofs_high;
  logic [1:0]    err;
  logic [8:0]    copy_left;
  logic [AW-1:0] src;
  logic [WW-1:0] word;
  logic [3:0]    k;
  logic          last_r;

  logic [7:0]    hist [WINDOW_BYTES];
  logic [7:0]    rd_q;
  logic          wr_en;
  logic [7:0]    wr_data;

  logic          accept;
  logic          can_emit;
  logic          emit;
  state_t        idle_next;
  logic [17:0]   lit_sum;
  logic [17:0]   copy_sum;
  logic [8:0]    copy_cnt;
  logic [16:0]   back_dist;
  logic [WW-1:0] word_next;

  assign pready    = 1'b1;
  assign prdata    = (paddr == REG_OUT_LIMIT) ? 32'(out_limit) : 32'd0;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign can_emit  = !out_valid || out_ready;
  assign emit      = can_emit &&
                     (state == S_LIT_EMIT || state == S_COPY_EMIT || state == S_CLOSE);
  assign idle_next = stream_end ? S_CLOSE : S_IDLE;

  assign lit_sum   = {1'b0, out_count} + 18'(in_byte) + 18'd1;
  assign copy_cnt  = mlen + MinMatch;
  assign copy_sum  = {1'b0, out_count} + 18'(copy_cnt);
  assign back_dist = 17'({ofs_high, in_byte}) + 17'd1;
  assign word_next = word | (WW'(rd_q) << {k, 3'b000});

  assign wr_en   = (accept && err == ST_OK && phase == P_LIT) || state == S_COPY_WR;
  assign wr_data = (state == S_COPY_WR) ? rd_q : in_byte;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist[out_count[AW-1:0]] <= wr_data;
    end
    if (state == S_COPY_RD) begin
      rd_q <= hist[src];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= OutLimitReset;
    end else if (psel && penable && pwrite && paddr == REG_OUT_LIMIT) begin
      out_limit <= pwdata[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      phase     <= P_CTRL;
      out_count <= '0;
      lit_left  <= '0;
      mlen      <= '0;
      ofs_high  <= '0;
      err       <= ST_OK;
      out_valid <= 1'b0;
      k         <= '0;
      word      <= '0;
      last_r    <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_r <= stream_end;
            if (err != ST_OK) begin
              state <= idle_next;
            end else begin
              unique case (phase)
                P_CTRL: begin
                  state <= idle_next;
                  if (!stream_end) begin
                    if (in_byte < LiteralCtrlTop) begin
                      if (lit_sum > {1'b0, out_limit}) begin
                        err <= ST_OVERFLOW;
                      end else begin
                        lit_left <= 6'(in_byte) + 6'd1;
                        phase    <= P_LIT;
                      end
                    end else begin
                      mlen     <= 9'(in_byte[7:5]) - 9'd1;
                      ofs_high <= in_byte[4:0];
                      phase    <= (9'(in_byte[7:5]) - 9'd1 == ExtendedLen) ? P_EXT : P_LOW;
                    end
                  end
                end
                P_LIT: begin
                  out_count <= out_count + 17'd1;
                  lit_left  <= lit_left - 6'd1;
                  word      <= WW'(in_byte);
                  state     <= S_LIT_EMIT;
                  if (lit_left == 6'd1) begin
                    phase <= P_CTRL;
                  end else if (stream_end) begin
                    err <= ST_TRUNC;
                  end
                end
                P_EXT: begin
                  state <= idle_next;
                  mlen  <= mlen + 9'(in_byte);
                  phase <= P_LOW;
                  if (stream_end) begin
                    err <= ST_TRUNC;
                  end
                end
                P_LOW: begin
                  phase <= P_CTRL;
                  if (copy_sum > {1'b0, out_limit}) begin
                    err   <= ST_OVERFLOW;
                    state <= idle_next;
                  end else if (back_dist > out_count) begin
                    err   <= ST_DISTANCE;
                    state <= idle_next;
                  end else begin
                    src       <= AW'(out_count - back_dist);
                    copy_left <= copy_cnt;
                    k         <= '0;
                    word      <= '0;
                    state     <= S_COPY_RD;
                  end
                end
                default: begin
                  phase <= P_CTRL;
                  state <= idle_next;
                end
              endcase
            end
          end
        end
        S_LIT_EMIT: begin
          if (can_emit) begin
            out_bytes    <= 64'(word);
            byte_count   <= 4'd1;
            total_length <= '0;
            status       <= ST_OK;
            block_done   <= 1'b0;
            run_last     <= !last_r;
            state        <= last_r ? S_CLOSE : S_IDLE;
          end
        end
        S_COPY_RD: begin
          src   <= src + AW'(1);
          state <= S_COPY_WR;
        end
        S_COPY_WR: begin
          word      <= word_next;
          k         <= k + 4'd1;
          out_count <= out_count + 17'd1;
          copy_left <= copy_left - 9'd1;
          if (k + 4'd1 == 4'(LANES) || copy_left == 9'd1) begin
            state <= S_COPY_EMIT;
          end else begin
            state <= S_COPY_RD;
          end
        end
        S_COPY_EMIT: begin
          if (can_emit) begin
            out_bytes    <= 64'(word);
            byte_count   <= k;
            total_length <= '0;
            status       <= ST_OK;
            block_done   <= 1'b0;
            run_last     <= (copy_left == 9'd0) && !last_r;
            k            <= '0;
            word         <= '0;
            if (copy_left != 9'd0) begin
              state <= S_COPY_RD;
            end else begin
              state <= last_r ? S_CLOSE : S_IDLE;
            end
          end
        end
        S_CLOSE: begin
          if (can_emit) begin
            out_bytes    <= '0;
            byte_count   <= '0;
            total_length <= (err == ST_OK) ? out_count : 17'd0;
            status       <= err;
            block_done   <= 1'b1;
            run_last     <= 1'b1;
            out_count    <= '0;
            phase        <= P_CTRL;
            lit_left     <= '0;
            mlen         <= '0;
            ofs_high     <= '0;
            err          <= ST_OK;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/tb_lzf_byte_decompressor.sv -----
module tb_lzf_byte_decompressor;
  import lzf_pkg::*;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  cnt;
    logic [16:0] total;
    logic [1:0]  stat;
    logic        done;
    logic        last;
  } chunk_t;

  typedef struct {
    logic [7:0] b;
    logic       e;
    logic       chk;
    chunk_t     want;
  } row_t;

  typedef enum logic [1:0] {PH_CTRL, PH_LIT, PH_EXT, PH_LOW} phase_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic [7:0] in_byte = '0;
  logic stream_end = 0;
  logic out_valid;
  logic out_ready = 0;
  logic [63:0] out_bytes;
  logic [3:0] byte_count;
  logic [16:0] total_length;
  logic [1:0] status;
  logic block_done;
  logic run_last;

  lzf_byte_decompressor dut (.*);

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  logic [7:0] hist [0:8191];
  logic [16:0] produced;
  phase_t phase;
  logic [5:0] lit_left;
  logic [8:0] mlen;
  logic [4:0] off_hi;
  logic [1:0] err;
  logic [16:0] limit;

  chunk_t expected_chunks[$];
  int fails = 0;
  int accepted_out = 0;
  int blocks_seen = 0;
  int idle_cycles = 0;
  bit no_idle = 0;
  bit hold_off = 0;

  function automatic chunk_t mk(logic [63:0] d, logic [3:0] c, logic [16:0] t,
                                logic [1:0] s, logic dn);
    chunk_t r;
    r.data = d; r.cnt = c; r.total = t; r.stat = s; r.done = dn; r.last = 0;
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic e);
    chunk_t res[$];
    logic [16:0] back_dist, n;
    logic [63:0] w;
    int k;
    if (err == ST_OK) begin
      case (phase)
        PH_CTRL: if (!e) begin
          if (b < LiteralCtrlTop) begin
            if (produced + b + 1 > limit) err = ST_OVERFLOW;
            else begin
              lit_left = 6'(b) + 6'd1;
              phase = PH_LIT;
            end
          end else begin
            mlen = 9'(b >> 5) - 9'd1;
            off_hi = b[4:0];
            phase = (mlen == ExtendedLen) ? PH_EXT : PH_LOW;
          end
        end
        PH_LIT: begin
          hist[produced[12:0]] = b;
          produced++;
          res.push_back(mk({56'd0, b}, 4'd1, 17'd0, ST_OK, 1'b0));
          lit_left--;
          if (lit_left == 0) phase = PH_CTRL;
          else if (e) err = ST_TRUNC;
        end
        PH_EXT: begin
          mlen = mlen + 9'(b);
          phase = PH_LOW;
          if (e) err = ST_TRUNC;
        end
        default: begin
          back_dist = 17'({off_hi, b}) + 17'd1;
          n = 17'(mlen + MinMatch);
          phase = PH_CTRL;
          if (produced + n > limit) err = ST_OVERFLOW;
          else if (back_dist > produced) err = ST_DISTANCE;
          else while (n > 0) begin
            w = '0;
            k = 0;
            while (k < 8 && n > 0) begin
              hist[produced[12:0]] = hist[13'(produced - back_dist)];
              w[8*k +: 8] = hist[produced[12:0]];
              produced++;
              k++;
              n--;
            end
            res.push_back(mk(w, 4'(k), 17'd0, ST_OK, 1'b0));
          end
        end
      endcase
    end
    if (e) begin
      res.push_back(mk('0, 4'd0, (err == ST_OK) ? produced : 17'd0, err, 1'b1));
      produced = 0; phase = PH_CTRL; lit_left = 0; mlen = 0; off_hi = 0; err = ST_OK;
    end
    if (res.size() > 0) res[res.size()-1].last = 1;
    foreach (res[i]) expected_chunks.push_back(res[i]);
  endtask

  task automatic send(input logic [7:0] b, input logic e);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < 26) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1; in_byte <= b; stream_end <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    decode_byte(b, e);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (expected_chunks.size() > 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_limit(input logic [16:0] v);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= REG_OUT_LIMIT; pwdata <= 32'(v);
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    limit = v;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  // random block of literal and match tokens, sometimes with a bad distance or a random closing byte
  task automatic random_block(input int toks);
    int written, len, d;
    written = 0;
    for (int t = 0; t < toks; t++) begin
      if (written == 0 || $urandom_range(2) == 0) begin
        len = $urandom_range(31);
        if ($urandom_range(3) != 0) len = $urandom_range(5);
        send(8'(len), 1'b0);
        for (int i = 0; i <= len; i++) send(8'($urandom), 1'b0);
        written += len + 1;
      end else begin
        len = $urandom_range(7, 1);
        d = $urandom_range((written > 8192 ? 8192 : written) - 1);
        if ($urandom_range(9) == 0) d = $urandom_range(8191);
        send({len[2:0], 5'(d >> 8)}, 1'b0);
        if (len == 7) send(8'($urandom_range(3) == 0 ? $urandom : $urandom_range(8)), 1'b0);
        send(d[7:0], 1'b0);
        written += ((len == 7) ? 6 : len - 1) + 3;
      end
    end
    case ($urandom_range(5))
      0: send(8'($urandom_range(4, 0)), 1'b1);
      1: send(8'($urandom) | 8'h20, 1'b1);
      default: send(8'($urandom), 1'b1);
    endcase
  endtask

  always @(posedge clk) begin
    chunk_t got, exp_c;
    if (!rst && out_valid && out_ready) begin
      accepted_out++;
      got = '{out_bytes, byte_count, total_length, status, block_done, run_last};
      if (block_done) blocks_seen++;
      if (expected_chunks.size() == 0) begin
        $error("unexpected result %h", got);
        fails++;
      end else begin
        exp_c = expected_chunks.pop_front();
        if (got.data !== exp_c.data) begin
          $error("out_bytes exp %h got %h", exp_c.data, got.data); fails++;
        end
        if (got.cnt !== exp_c.cnt) begin
          $error("byte_count exp %0d got %0d", exp_c.cnt, got.cnt); fails++;
        end
        if (got.total !== exp_c.total) begin
          $error("total_length exp %0d got %0d", exp_c.total, got.total); fails++;
        end
        if (got.stat !== exp_c.stat) begin
          $error("status exp %0d got %0d", exp_c.stat, got.stat); fails++;
        end
        if (got.done !== exp_c.done) begin
          $error("block_done exp %0d got %0d", exp_c.done, got.done); fails++;
        end
        if (got.last !== exp_c.last) begin
          $error("run_last exp %0d got %0d", exp_c.last, got.last); fails++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_ready <= 0;
    else out_ready <= no_idle || ($urandom_range(99) >= 26);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  row_t dir_rows[$];

  function automatic row_t r(logic [7:0] b, logic e, logic c = 0, chunk_t w = '0);
    row_t x;
    x.b = b; x.e = e; x.chk = c; x.want = w;
    return x;
  endfunction

  initial begin
    chunk_t c;
    produced = 0; phase = PH_CTRL; lit_left = 0; mlen = 0; off_hi = 0;
    err = ST_OK; limit = OutLimitReset;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    c = mk('0, 4'd0, 17'd0, ST_OK, 1'b1); c.last = 1;
    dir_rows.push_back(r(8'h05, 1, 1, c));          // lone final control byte
    dir_rows.push_back(r(8'h01, 0));
    dir_rows.push_back(r(8'h00, 0));
    dir_rows.push_back(r(8'hFF, 0));
    dir_rows.push_back(r(8'h20, 0));                // len 3, dist 1
    dir_rows.push_back(r(8'h00, 0));
    dir_rows.push_back(r(8'hE0, 0));                // extended length
    dir_rows.push_back(r(8'hFF, 0));
    dir_rows.push_back(r(8'h01, 0));
    c = mk('0, 4'd0, 17'd0, ST_DISTANCE, 1'b1); c.last = 1;
    dir_rows.push_back(r(8'h3F, 0));                // distance too far
    dir_rows.push_back(r(8'hFF, 0));
    dir_rows.push_back(r(8'h00, 1, 1, c));
    dir_rows.push_back(r(8'h1F, 0));
    dir_rows.push_back(r(8'hAA, 1));                // truncated literal
    dir_rows.push_back(r(8'h00, 0));
    dir_rows.push_back(r(8'h55, 0));
    dir_rows.push_back(r(8'hE0, 0));
    dir_rows.push_back(r(8'h10, 1));                // truncated extension
    foreach (dir_rows[i]) begin
      if (dir_rows[i].chk) begin
        send(dir_rows[i].b, dir_rows[i].e);
        expected_chunks.pop_back();
        expected_chunks.push_back(dir_rows[i].want);
      end else send(dir_rows[i].b, dir_rows[i].e);
    end
    drain();

    set_limit(17'd0);
    send(8'h00, 1'b0); send(8'h00, 1'b1);           // overflow at zero limit
    drain();
    set_limit(17'd20);
    random_block(4);
    random_block(3);
    drain();
    set_limit(17'd65536);

    no_idle = 1;
    random_block(6);
    no_idle = 0;

    fork
      begin
        hold_off = 1;
        repeat (400) @(negedge clk);
        hold_off = 0;
      end
      random_block(5);
    join

    while (blocks_seen < 10 || accepted_out < 160) random_block($urandom_range(8, 2));
    drain();
    set_limit(17'd100);
    random_block(10);
    random_block(10);
    drain();
    $display("covered literals, overlapping copies, extended lengths, all status codes");
    $display("%0d results, %0d blocks, limits 0..65536", accepted_out, blocks_seen);
    if (fails == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/lzf_pkg.sv
rtl/lzf_byte_decompressor.sv
tb/tb_lzf_byte_decompressor.sv
